/* rtl/core/sha1_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and round helpers for the SHA-1 message digest core.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned BLOCK_W = 512;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned RND_W   = 7;
    localparam int unsigned COUNT_W = 61;

    localparam logic [POS_W-1:0] POS_LAST    = 6'd63;
    localparam logic [POS_W-1:0] POS_LEN     = 6'd56;
    localparam logic [RND_W-1:0] RND_LAST    = 7'd79;
    localparam logic [RND_W-1:0] RND_PHASE1  = 7'd20;
    localparam logic [RND_W-1:0] RND_PHASE2  = 7'd40;
    localparam logic [RND_W-1:0] RND_PHASE3  = 7'd60;
    localparam logic [7:0]       PAD_MARK    = 8'h80;

    localparam logic [WORD_W-1:0] IV0 = 32'h67452301;
    localparam logic [WORD_W-1:0] IV1 = 32'hEFCDAB89;
    localparam logic [WORD_W-1:0] IV2 = 32'h98BADCFE;
    localparam logic [WORD_W-1:0] IV3 = 32'h10325476;
    localparam logic [WORD_W-1:0] IV4 = 32'hC3D2E1F0;

    typedef enum logic [1:0] {
        PH_CH  = 2'd0,
        PH_XOR = 2'd1,
        PH_MAJ = 2'd2,
        PH_PAR = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE    = 3'd0,
        S_PAD80   = 3'd1,
        S_PADZERO = 3'd2,
        S_PADLEN  = 3'd3,
        S_ROUND   = 3'd4,
        S_UPDATE  = 3'd5,
        S_OUT     = 3'd6
    } t_state;

    typedef enum logic [1:0] {
        SRC_DATA = 2'd0,
        SRC_MARK = 2'd1,
        SRC_ZERO = 2'd2,
        SRC_LEN  = 2'd3
    } t_src;

    typedef struct packed {
        logic   shift;
        t_src   src;
        logic   load_rounds;
        logic   round;
        t_phase phase;
        logic   update;
        logic   finish;
    } t_cmd;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             out_full;
    } t_status;

    function automatic logic [WORD_W-1:0] iv_word(input logic [2:0] idx);
        logic [WORD_W-1:0] v;
        case (idx)
            3'd0:    v = IV0;
            3'd1:    v = IV1;
            3'd2:    v = IV2;
            3'd3:    v = IV3;
            default: v = IV4;
        endcase
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] round_k(input t_phase ph);
        logic [WORD_W-1:0] k;
        case (ph)
            PH_CH:   k = 32'h5A827999;
            PH_XOR:  k = 32'h6ED9EBA1;
            PH_MAJ:  k = 32'h8F1BBCDC;
            PH_PAR:  k = 32'hCA62C1D6;
            default: k = 32'h5A827999;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/sha1_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_ctrl
// Sequencer: word intake, padding, 80-round compression and digest hand-off.
// ----------------------------------------------------------------------------
module sha1_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_byte_present,
    input  wire logic              i_final_item,
    input  wire sha1_pkg::t_status i_status,
    output logic                   o_ready,
    output sha1_pkg::t_cmd         o_cmd
);

    sha1_pkg::t_state                r_state, n_state;
    sha1_pkg::t_state                r_ret, n_ret;
    logic [sha1_pkg::RND_W-1:0]      r_rnd, n_rnd;

    logic w_acc;
    logic w_full;
    logic w_out_free;

    assign w_acc      = i_valid && (r_state == sha1_pkg::S_IDLE);
    assign w_full     = (i_status.pos == sha1_pkg::POS_LAST);
    assign w_out_free = !i_status.out_full;

    // next state
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_rnd   = r_rnd;
        case (r_state)
            sha1_pkg::S_IDLE: begin
                if (w_acc) begin
                    if (i_byte_present && w_full) begin
                        n_state = sha1_pkg::S_ROUND;
                        n_rnd   = '0;
                        n_ret   = i_final_item ? sha1_pkg::S_PAD80 : sha1_pkg::S_IDLE;
                    end else if (i_final_item) begin
                        n_state = sha1_pkg::S_PAD80;
                    end
                end
            end
            sha1_pkg::S_PAD80: begin
                if (w_full) begin
                    n_state = sha1_pkg::S_ROUND;
                    n_rnd   = '0;
                    n_ret   = sha1_pkg::S_PADZERO;
                end else begin
                    n_state = sha1_pkg::S_PADZERO;
                end
            end
            sha1_pkg::S_PADZERO: begin
                if (i_status.pos == sha1_pkg::POS_LEN) begin
                    n_state = sha1_pkg::S_PADLEN;
                end else if (w_full) begin
                    n_state = sha1_pkg::S_ROUND;
                    n_rnd   = '0;
                    n_ret   = sha1_pkg::S_PADZERO;
                end
            end
            sha1_pkg::S_PADLEN: begin
                if (w_full) begin
                    n_state = sha1_pkg::S_ROUND;
                    n_rnd   = '0;
                    n_ret   = sha1_pkg::S_OUT;
                end
            end
            sha1_pkg::S_ROUND: begin
                n_rnd = r_rnd + 1'b1;
                if (r_rnd == sha1_pkg::RND_LAST) begin
                    n_state = sha1_pkg::S_UPDATE;
                end
            end
            sha1_pkg::S_UPDATE: begin
                n_state = r_ret;
            end
            sha1_pkg::S_OUT: begin
                if (w_out_free || i_status.out_full) begin
                    // wait until the output register can take the digest
                    if (w_out_free) begin
                        n_state = sha1_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = sha1_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ready           = (r_state == sha1_pkg::S_IDLE);
        o_cmd             = '0;
        o_cmd.src         = sha1_pkg::SRC_DATA;
        o_cmd.phase       = sha1_pkg::PH_CH;
        case (r_state)
            sha1_pkg::S_IDLE: begin
                o_cmd.shift       = w_acc && i_byte_present;
                o_cmd.load_rounds = w_acc && i_byte_present && w_full;
            end
            sha1_pkg::S_PAD80: begin
                o_cmd.shift       = 1'b1;
                o_cmd.src         = sha1_pkg::SRC_MARK;
                o_cmd.load_rounds = w_full;
            end
            sha1_pkg::S_PADZERO: begin
                o_cmd.shift       = (i_status.pos != sha1_pkg::POS_LEN);
                o_cmd.src         = sha1_pkg::SRC_ZERO;
                o_cmd.load_rounds = w_full;
            end
            sha1_pkg::S_PADLEN: begin
                o_cmd.shift       = 1'b1;
                o_cmd.src         = sha1_pkg::SRC_LEN;
                o_cmd.load_rounds = w_full;
            end
            sha1_pkg::S_ROUND: begin
                o_cmd.round = 1'b1;
                if (r_rnd < sha1_pkg::RND_PHASE1) begin
                    o_cmd.phase = sha1_pkg::PH_CH;
                end else if (r_rnd < sha1_pkg::RND_PHASE2) begin
                    o_cmd.phase = sha1_pkg::PH_XOR;
                end else if (r_rnd < sha1_pkg::RND_PHASE3) begin
                    o_cmd.phase = sha1_pkg::PH_MAJ;
                end else begin
                    o_cmd.phase = sha1_pkg::PH_PAR;
                end
            end
            sha1_pkg::S_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            sha1_pkg::S_OUT: begin
                o_cmd.finish = w_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha1_pkg::S_IDLE;
            r_ret   <= sha1_pkg::S_IDLE;
            r_rnd   <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_rnd   <= n_rnd;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/sha1_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_dp
// Datapath: block shift register and message schedule, round unit,
// chaining value, length counter and digest output register.
// ----------------------------------------------------------------------------
module sha1_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire sha1_pkg::t_cmd                i_cmd,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic                          i_ready,
    output sha1_pkg::t_status                  o_status,
    output logic                               o_valid,
    output logic [sha1_pkg::WORD_W-1:0]        o_digest_word0,
    output logic [sha1_pkg::WORD_W-1:0]        o_digest_word1,
    output logic [sha1_pkg::WORD_W-1:0]        o_digest_word2,
    output logic [sha1_pkg::WORD_W-1:0]        o_digest_word3,
    output logic [sha1_pkg::WORD_W-1:0]        o_digest_word4
);

    logic [sha1_pkg::BLOCK_W-1:0]   r_blk;
    logic [sha1_pkg::WORD_W-1:0]    r_h   [5];
    logic [sha1_pkg::WORD_W-1:0]    r_v   [5];
    logic [sha1_pkg::WORD_W-1:0]    r_out [5];
    logic [sha1_pkg::COUNT_W-1:0]   r_count;
    logic [sha1_pkg::POS_W-1:0]     r_pos;
    logic                           r_out_valid;

    logic [63:0]                    w_bits;
    logic [7:0]                     w_byte;
    logic [sha1_pkg::WORD_W-1:0]    w_wt;
    logic [sha1_pkg::WORD_W-1:0]    w_mix;
    logic [sha1_pkg::WORD_W-1:0]    w_next_w;
    logic [sha1_pkg::WORD_W-1:0]    w_f;
    logic [sha1_pkg::WORD_W-1:0]    w_tmp;
    logic [2:0]                     w_len_idx;

    assign w_bits    = {r_count, 3'b000};
    assign w_len_idx = 3'd7 - r_pos[2:0];

    always_comb begin
        case (i_cmd.src)
            sha1_pkg::SRC_DATA: w_byte = i_data_byte;
            sha1_pkg::SRC_MARK: w_byte = sha1_pkg::PAD_MARK;
            sha1_pkg::SRC_ZERO: w_byte = 8'h00;
            sha1_pkg::SRC_LEN:  w_byte = w_bits[{w_len_idx, 3'b000} +: 8];
            default:            w_byte = 8'h00;
        endcase
    end

    // schedule window: word 0 at the top is w[t], word 15 at the bottom
    assign w_wt     = r_blk[511:480];
    assign w_mix    = r_blk[95:64] ^ r_blk[255:224] ^ r_blk[447:416] ^ r_blk[511:480];
    assign w_next_w = {w_mix[30:0], w_mix[31]};

    always_comb begin
        case (i_cmd.phase)
            sha1_pkg::PH_CH:  w_f = (r_v[1] & r_v[2]) | (~r_v[1] & r_v[3]);
            sha1_pkg::PH_MAJ: w_f = (r_v[1] & r_v[2]) | (r_v[1] & r_v[3]) | (r_v[2] & r_v[3]);
            sha1_pkg::PH_XOR: w_f = r_v[1] ^ r_v[2] ^ r_v[3];
            sha1_pkg::PH_PAR: w_f = r_v[1] ^ r_v[2] ^ r_v[3];
            default:          w_f = r_v[1] ^ r_v[2] ^ r_v[3];
        endcase
    end

    assign w_tmp = {r_v[0][26:0], r_v[0][31:27]} + w_f + r_v[4] + w_wt
                 + sha1_pkg::round_k(i_cmd.phase);

    // block and schedule
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_blk <= {r_blk[sha1_pkg::BLOCK_W-9:0], w_byte};
        end else if (i_cmd.round) begin
            r_blk <= {r_blk[sha1_pkg::BLOCK_W-33:0], w_next_w};
        end
    end

    // working variables a..e
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rounds) begin
            for (int i = 0; i < 5; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (i_cmd.round) begin
            r_v[0] <= w_tmp;
            r_v[1] <= r_v[0];
            r_v[2] <= {r_v[1][1:0], r_v[1][31:2]};
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3];
        end
    end

    // chaining value, counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                r_h[i] <= sha1_pkg::iv_word(3'(i));
            end
            r_count <= '0;
            r_pos   <= '0;
        end else begin
            if (i_cmd.update) begin
                for (int i = 0; i < 5; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end else if (i_cmd.finish) begin
                for (int i = 0; i < 5; i++) begin
                    r_h[i] <= sha1_pkg::iv_word(3'(i));
                end
            end
            if (i_cmd.finish) begin
                r_count <= '0;
                r_pos   <= '0;
            end else if (i_cmd.shift) begin
                r_pos <= r_pos + 1'b1;
                if (i_cmd.src == sha1_pkg::SRC_DATA) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // digest output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            for (int i = 0; i < 5; i++) begin
                r_out[i] <= r_h[i];
            end
        end
    end

    assign o_status.pos      = r_pos;
    assign o_status.out_full = r_out_valid && !i_ready;

    assign o_valid        = r_out_valid;
    assign o_digest_word0 = r_out[0];
    assign o_digest_word1 = r_out[1];
    assign o_digest_word2 = r_out[2];
    assign o_digest_word3 = r_out[3];
    assign o_digest_word4 = r_out[4];

endmodule
`default_nettype wire

/* rtl/core/sha1_message_digest.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_message_digest
// Streaming SHA-1 hasher, one message byte per input word, digest out.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while a 512-bit block fills. The 64th byte of
// a block starts the compression on a single round unit: 80 rounds, one per
// cycle, then the chaining add; input stalls until the block is folded in.
// A word with i_final_item set starts padding, with intake held off, which
// shifts in pad bytes up to the end of the block, then one compression (two
// when the message ends at block position 56 or later); once the output
// register is free, the digest is loaded into it. The digest sits in an output
// register, so the next message can start while it waits to be taken.
module sha1_message_digest (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_present,
    input  wire logic        i_final_item,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_digest_word0,
    output logic [31:0]      o_digest_word1,
    output logic [31:0]      o_digest_word2,
    output logic [31:0]      o_digest_word3,
    output logic [31:0]      o_digest_word4
);

    sha1_pkg::t_cmd    w_cmd;
    sha1_pkg::t_status w_status;

    sha1_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_byte_present (i_byte_present),
        .i_final_item   (i_final_item),
        .i_status       (w_status),
        .o_ready        (o_ready),
        .o_cmd          (w_cmd)
    );

    sha1_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_data_byte    (i_data_byte),
        .i_ready        (i_ready),
        .o_status       (w_status),
        .o_valid        (o_valid),
        .o_digest_word0 (o_digest_word0),
        .o_digest_word1 (o_digest_word1),
        .o_digest_word2 (o_digest_word2),
        .o_digest_word3 (o_digest_word3),
        .o_digest_word4 (o_digest_word4)
    );

    logic w_in_acc;
    assign w_in_acc = i_valid && o_ready;

    // final word always leads into padding, never straight back to intake
    a_final_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_final_item |=> !o_ready)
        else $error("input ready right after final word");

    // a byte that does not close a block keeps intake open
    a_byte_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_byte_present && !i_final_item
        && w_status.pos != sha1_pkg::POS_LAST |=> o_ready)
        else $error("intake stalled mid-block");

    // a new digest only appears on a block boundary
    a_digest_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> w_status.pos == '0)
        else $error("digest issued off block boundary");

endmodule
`default_nettype wire

/* tb/tb_sha1_message_digest.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha1_message_digest
// Self-checking bench for the streaming SHA-1 hasher. Messages go in one
// byte per word and a local SHA-1 model predicts each digest. Digests are
// checked in order, word by word, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_sha1_message_digest;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES   = 300;
    localparam int unsigned TARGET_ITEMS   = 1050;

    localparam logic [31:0] H_INIT0 = 32'h67452301;
    localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
    localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
    localparam logic [31:0] H_INIT3 = 32'h10325476;
    localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;
    localparam logic [31:0] K_CH    = 32'h5A827999;
    localparam logic [31:0] K_PAR1  = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ   = 32'h8F1BBCDC;
    localparam logic [31:0] K_PAR2  = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;
    typedef enum int {END_ON_BYTE, END_SEPARATE} t_ending;
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKED} t_rx_mode;

    typedef struct {
        logic [7:0] data;
        logic       present;
        logic       ends;
        logic       hold;
    } t_byte_item;

    typedef struct packed {
        logic [31:0] h0;
        logic [31:0] h1;
        logic [31:0] h2;
        logic [31:0] h3;
        logic [31:0] h4;
    } t_digest;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [7:0]  i_data_byte    = 8'h00;
    logic        i_byte_present = 1'b0;
    logic        i_final_item   = 1'b0;
    logic        i_ready        = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_digest_word0;
    logic [31:0] o_digest_word1;
    logic [31:0] o_digest_word2;
    logic [31:0] o_digest_word3;
    logic [31:0] o_digest_word4;

    sha1_message_digest dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_final_item   (i_final_item),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_digest_word0 (o_digest_word0),
        .o_digest_word1 (o_digest_word1),
        .o_digest_word2 (o_digest_word2),
        .o_digest_word3 (o_digest_word3),
        .o_digest_word4 (o_digest_word4)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // SHA-1 predictor
    // ------------------------------------------------------------------------
    logic [31:0] hash_state [5];
    logic [31:0] msg_block  [16];
    logic [60:0] msg_bytes;
    t_digest     digests_due [$];

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void restart_message();
        hash_state[0] = H_INIT0;
        hash_state[1] = H_INIT1;
        hash_state[2] = H_INIT2;
        hash_state[3] = H_INIT3;
        hash_state[4] = H_INIT4;
        msg_bytes     = '0;
    endfunction

    function automatic void fold_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, t_sum;
        int t;
        w = msg_block;
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (t = 0; t < 80; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                // schedule kept as a rolling 16-word window
                wt = rotl(w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16], 1);
                w[t % 16] = wt;
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = K_CH;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K_PAR1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJ;
            end else begin
                f = b ^ c ^ d;
                k = K_PAR2;
            end
            t_sum = rotl(a, 5) + f + e + wt + k;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t_sum;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endfunction

    // big-endian packing: block byte 0 lands in the top byte of word 0
    function automatic void put_byte(input logic [5:0] pos, input logic [7:0] value);
        logic [4:0] sh;
        sh = {~pos[1:0], 3'b000};
        if (pos[1:0] == 2'd0) begin
            msg_block[pos[5:2]] = {24'b0, value} << sh;
        end else begin
            msg_block[pos[5:2]] |= {24'b0, value} << sh;
        end
    endfunction

    function automatic void absorb_item(input logic [7:0] data, input logic present,
                                        input logic ends);
        logic [5:0]  pos;
        logic [63:0] bit_len;
        t_digest     dg;
        int          i;
        if (present) begin
            pos = msg_bytes[5:0];
            put_byte(pos, data);
            msg_bytes = msg_bytes + 1'b1;
            if (pos == 6'd63) begin
                fold_block();
            end
        end
        if (ends) begin
            pos = msg_bytes[5:0];
            put_byte(pos, PAD_BYTE);
            for (i = int'(pos) + 1; i < 64; i++) begin
                put_byte(i[5:0], 8'h00);
            end
            // no room left for the length: spill into an extra block
            if (pos >= 6'd56) begin
                fold_block();
                for (i = 0; i < 16; i++) begin
                    msg_block[i] = '0;
                end
            end
            bit_len       = {msg_bytes, 3'b000};
            msg_block[14] = bit_len[63:32];
            msg_block[15] = bit_len[31:0];
            fold_block();
            dg.h0 = hash_state[0];
            dg.h1 = hash_state[1];
            dg.h2 = hash_state[2];
            dg.h3 = hash_state[3];
            dg.h4 = hash_state[4];
            digests_due.push_back(dg);
            restart_message();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    t_byte_item  byte_items [$];
    int unsigned n_items;

    function automatic void push_item(input logic [7:0] data, input logic present,
                                      input logic ends, input logic hold);
        t_byte_item it;
        it.data    = data;
        it.present = present;
        it.ends    = ends;
        it.hold    = hold;
        byte_items.push_back(it);
        n_items++;
    endfunction

    function automatic void add_message(input int unsigned len, input t_fill fill,
                                        input t_ending ending, input logic hold,
                                        input int unsigned idle_pct);
        int unsigned n;
        logic [7:0]  value;
        logic        last_byte;
        // an empty message can only end on a word without a byte
        if (len == 0) begin
            ending = END_SEPARATE;
        end
        for (n = 0; n < len; n++) begin
            case (fill)
                FILL_ZERO: value = 8'h00;
                FILL_ONES: value = 8'hFF;
                default:   value = 8'($urandom);
            endcase
            last_byte = (n == len - 1) && (ending == END_ON_BYTE);
            push_item(value, 1'b1, last_byte, hold && (n == 0));
            if (!last_byte && $urandom_range(99, 0) < idle_pct) begin
                push_item(8'($urandom), 1'b0, 1'b0, 1'b0);
            end
        end
        if (ending == END_SEPARATE) begin
            push_item(8'($urandom), 1'b0, 1'b1, hold && (len == 0));
        end
    endfunction

    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 70) begin
            return $urandom_range(12, 1);
        end else if (r < 85) begin
            return $urandom_range(70, 50);
        end else if (r < 92) begin
            return $urandom_range(130, 110);
        end else if (r < 97) begin
            return $urandom_range(3, 0);
        end
        return $urandom_range(300, 150);
    endfunction

    task automatic build_stimulus();
        int unsigned boundary [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
        int unsigned i;
        t_fill       fill;
        n_items = 0;
        // directed: empty messages, short ones, all-zero and all-one bytes
        add_message(0, FILL_RANDOM, END_SEPARATE, 1'b1, 0);
        push_item(8'hFF, 1'b0, 1'b0, 1'b0);
        add_message(0, FILL_RANDOM, END_SEPARATE, 1'b0, 0);
        push_item(8'h61, 1'b1, 1'b0, 1'b0);
        push_item(8'h62, 1'b1, 1'b0, 1'b0);
        push_item(8'h63, 1'b1, 1'b1, 1'b0);
        add_message(1, FILL_ZERO, END_ON_BYTE, 1'b0, 0);
        add_message(1, FILL_ONES, END_SEPARATE, 1'b0, 0);
        push_item(8'h61, 1'b1, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0, 1'b0);
        push_item(8'h62, 1'b1, 1'b0, 1'b0);
        push_item(8'hA5, 1'b0, 1'b1, 1'b1);
        add_message(2, FILL_ONES, END_ON_BYTE, 1'b0, 0);

        // lengths around the padding boundaries, random content
        for (i = 0; i < 8; i++) begin
            add_message(boundary[i], FILL_RANDOM,
                        ($urandom_range(1, 0) != 0) ? END_ON_BYTE : END_SEPARATE,
                        1'b0, 3);
        end

        while (n_items < TARGET_ITEMS) begin
            case ($urandom_range(19, 0))
                0:       fill = FILL_ZERO;
                1:       fill = FILL_ONES;
                default: fill = FILL_RANDOM;
            endcase
            add_message(pick_length(), fill,
                        ($urandom_range(1, 0) != 0) ? END_ON_BYTE : END_SEPARATE,
                        ($urandom_range(9, 0) == 0), 4);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: one word at a time, bursts with random gaps
    // ------------------------------------------------------------------------
    int unsigned sent_cnt     = 0;
    int unsigned accepted_cnt = 0;
    int unsigned burst_left   = 0;
    int unsigned gap_left     = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && accepted_cnt != sent_cnt) begin
            // hold the word until it is taken
        end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            i_valid  <= 1'b0;
        end else if (byte_items.size() == 0) begin
            i_valid <= 1'b0;
        end else if (byte_items[0].hold && digests_due.size() != 0) begin
            i_valid <= 1'b0;
        end else begin
            i_data_byte    <= byte_items[0].data;
            i_byte_present <= byte_items[0].present;
            i_final_item   <= byte_items[0].ends;
            i_valid        <= 1'b1;
            void'(byte_items.pop_front());
            sent_cnt <= sent_cnt + 1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(30, 1);
                case ($urandom_range(7, 0))
                    0, 1, 2: gap_left <= 0;
                    3:       gap_left <= $urandom_range(60, 20);
                    default: gap_left <= $urandom_range(8, 1);
                endcase
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern that changes mode every so often
    // ------------------------------------------------------------------------
    t_rx_mode    rx_mode  = RX_OPEN;
    int unsigned rx_timer = 0;

    always @(negedge i_clk) begin
        if (rx_timer == 0) begin
            rx_mode  <= t_rx_mode'($urandom_range(3, 0));
            rx_timer <= $urandom_range(200, 20);
            i_ready  <= 1'b1;
        end else begin
            rx_timer <= rx_timer - 1;
            case (rx_mode)
                RX_OPEN:   i_ready <= 1'b1;
                RX_COIN:   i_ready <= ($urandom_range(1, 0) != 0);
                RX_SPARSE: i_ready <= ($urandom_range(3, 0) == 0);
                default:   i_ready <= (rx_timer[4:0] == 5'd0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on input handshakes, check on output handshakes
    // ------------------------------------------------------------------------
    int unsigned fail_count = 0;
    int unsigned idle_count = 0;

    function automatic void check_word(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %08h, actual %08h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_digest want;
        if (!i_rst_n) begin
            restart_message();
            idle_count <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (digests_due.size() == 0) begin
                    $error("digest with no message pending: %08h %08h %08h %08h %08h",
                           o_digest_word0, o_digest_word1, o_digest_word2,
                           o_digest_word3, o_digest_word4);
                    fail_count++;
                end else begin
                    want = digests_due.pop_front();
                    check_word("digest_word0", want.h0, o_digest_word0);
                    check_word("digest_word1", want.h1, o_digest_word1);
                    check_word("digest_word2", want.h2, o_digest_word2);
                    check_word("digest_word3", want.h3, o_digest_word3);
                    check_word("digest_word4", want.h4, o_digest_word4);
                end
            end
            if (i_valid && o_ready) begin
                absorb_item(i_data_byte, i_byte_present, i_final_item);
                accepted_cnt <= accepted_cnt + 1;
            end
            if ((o_valid && i_ready) || (i_valid && o_ready)) begin
                idle_count <= 0;
            end else begin
                idle_count <= idle_count + 1;
            end
            if (idle_count >= WATCHDOG_LIMIT) begin
                $display("tb_sha1_message_digest: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, run, drain, verdict
    // ------------------------------------------------------------------------
    initial begin
        build_stimulus();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (byte_items.size() != 0 || i_valid || accepted_cnt != sent_cnt
               || digests_due.size() != 0) begin
            @(posedge i_clk);
        end
        // catch any stray digest after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_sha1_message_digest: PASS");
        end else begin
            $display("tb_sha1_message_digest: FAIL");
        end
        $finish;
    end

endmodule
